@@ rtl/dce_pkg.sv @@
package dce_pkg;

   localparam int ADDR_W    = 13;
   localparam int VALUE_W   = 16;
   localparam int CFG_W     = 5;
   localparam int KSIDE_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int ACC_W     = 48;
   localparam int PROD_W    = 32;
   localparam int FRAC_W    = 8;

   localparam int RST_CHANNELS = 16;
   localparam int RST_SIDE     = 19;
   localparam int RST_KERNEL   = 3;

   localparam logic [VALUE_W-1:0] VALUE_POS_LIMIT = 16'h7FFF;
   localparam logic [VALUE_W-1:0] VALUE_NEG_LIMIT = 16'h8000;

   typedef enum logic [1:0] {
      REQ_LOAD_ACT  = 2'd0,
      REQ_LOAD_WGT  = 2'd1,
      REQ_LOAD_BIAS = 2'd2,
      REQ_COMPUTE   = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OUT_CHANNELS = 3'd0,
      REG_IN_CHANNELS  = 3'd1,
      REG_OUT_SIDE     = 3'd2,
      REG_IN_SIDE      = 3'd3,
      REG_KERNEL_SIDE  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVC,
      ST_DIVR,
      ST_BIAS,
      ST_TAPS,
      ST_DRAIN
   } ctrl_state_type;

   typedef struct packed {
      logic [CFG_W-1:0]   out_channel_count;
      logic [CFG_W-1:0]   in_channel_count;
      logic [CFG_W-1:0]   out_side;
      logic [CFG_W-1:0]   in_side;
      logic [KSIDE_W-1:0] kernel_side;
   } cfg_type;

   typedef struct packed {
      logic load_write;
      logic capture;
      logic oc_step;
      logic row_step;
      logic tap_init;
      logic tap_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic rem_ge_plane;
      logic oc_last;
      logic rem_ge_side;
      logic tap_last;
      logic pipe_busy;
      logic out_busy;
   } stat_type;

   function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v, input int hi);
      if (v == '0) return CFG_W'(1);
      if (int'(v) > hi) return CFG_W'(hi);
      return v;
   endfunction

endpackage

@@ rtl/dce_req_if.sv @@
interface dce_req_if import dce_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                req_type;
   logic [ADDR_W-1:0]         addr;
   logic signed [VALUE_W-1:0] load_value;

   modport source (output valid, req_type, addr, load_value, input ready);
   modport sink   (input valid, req_type, addr, load_value, output ready);
endinterface

@@ rtl/dce_rsp_if.sv @@
interface dce_rsp_if import dce_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [ADDR_W-1:0]         out_addr;
   logic signed [VALUE_W-1:0] out_value;
   logic                      saturated;

   modport source (output valid, out_addr, out_value, saturated, input ready);
   modport sink   (input valid, out_addr, out_value, saturated, output ready);
endinterface

@@ rtl/dce_csr_if.sv @@
interface dce_csr_if import dce_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/dce_csr.sv @@
module dce_csr import dce_pkg::*; #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int MAX_SIDE         = 19,
   parameter int MAX_KERNEL       = 3
) (
   input  logic    clock,
   input  logic    reset,
   dce_csr_if.sink csr_bus,
   output cfg_type cfg
);

   localparam logic [CFG_W-1:0] RST_OCC = clamp_cfg(CFG_W'(RST_CHANNELS), MAX_OUT_CHANNELS);
   localparam logic [CFG_W-1:0] RST_ICC = clamp_cfg(CFG_W'(RST_CHANNELS), MAX_IN_CHANNELS);
   localparam logic [CFG_W-1:0] RST_SD  = clamp_cfg(CFG_W'(RST_SIDE), MAX_SIDE);
   localparam logic [CFG_W-1:0] RST_K   = clamp_cfg(CFG_W'(RST_KERNEL), MAX_KERNEL);

   cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   // out-of-range writes are pulled into [1, MAX]
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_OUT_CHANNELS: cfg_in.out_channel_count = clamp_cfg(csr_bus.data, MAX_OUT_CHANNELS);
            REG_IN_CHANNELS:  cfg_in.in_channel_count  = clamp_cfg(csr_bus.data, MAX_IN_CHANNELS);
            REG_OUT_SIDE:     cfg_in.out_side          = clamp_cfg(csr_bus.data, MAX_SIDE);
            REG_IN_SIDE:      cfg_in.in_side           = clamp_cfg(csr_bus.data, MAX_SIDE);
            REG_KERNEL_SIDE:  cfg_in.kernel_side       = KSIDE_W'(clamp_cfg(
                                 CFG_W'(csr_bus.data[KSIDE_W-1:0]), MAX_KERNEL));
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.out_channel_count <= RST_OCC;
         cfg_ff.in_channel_count  <= RST_ICC;
         cfg_ff.out_side          <= RST_SD;
         cfg_ff.in_side           <= RST_SD;
         cfg_ff.kernel_side       <= KSIDE_W'(RST_K);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/dce_ctrl.sv @@
module dce_ctrl import dce_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_is_compute,
   input  stat_type stat,
   output logic     req_ready,
   output cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_is_compute) state_in = ST_DIVC;
         end
         ST_DIVC: begin
            if (!stat.rem_ge_plane)  state_in = ST_DIVR;
            else if (stat.oc_last)   state_in = ST_IDLE;  // index past the last channel: dropped
         end
         ST_DIVR: begin
            if (!stat.rem_ge_side) state_in = ST_BIAS;
         end
         ST_BIAS: state_in = ST_TAPS;
         ST_TAPS: begin
            if (stat.tap_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy && !stat.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.capture    = req_valid && req_is_compute;
            cmd.load_write = req_valid && !req_is_compute;
         end
         ST_DIVC:  cmd.oc_step  = stat.rem_ge_plane && !stat.oc_last;
         ST_DIVR:  cmd.row_step = stat.rem_ge_side;
         ST_BIAS:  cmd.tap_init = 1'b1;
         ST_TAPS:  cmd.tap_step = 1'b1;
         ST_DRAIN: cmd.finish   = !stat.pipe_busy && !stat.out_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/dce_datapath.sv @@
module dce_datapath import dce_pkg::*; #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int MAX_SIDE         = 19,
   parameter int MAX_KERNEL       = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  cmd_type                   cmd,
   input  logic [1:0]                req_type,
   input  logic [ADDR_W-1:0]         req_addr,
   input  logic signed [VALUE_W-1:0] req_load_value,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [ADDR_W-1:0]         rsp_out_addr,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic                      rsp_saturated,
   output stat_type                  stat
);

   localparam int ACT_DEPTH  = MAX_IN_CHANNELS * MAX_SIDE * MAX_SIDE;
   localparam int WGT_DEPTH  = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int BIAS_DEPTH = MAX_OUT_CHANNELS;
   localparam int ACT_AW     = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
   localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
   localparam int BIAS_AW    = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
   localparam int ROW_W      = CFG_W + 1;
   localparam int PLANE_W    = 2 * CFG_W;
   localparam int AREA_W     = 2 * KSIDE_W;
   localparam int STRIDE_W   = CFG_W + AREA_W;
   localparam int Q_W        = ACC_W - FRAC_W;

   logic signed [VALUE_W-1:0] act_mem  [ACT_DEPTH];
   logic signed [VALUE_W-1:0] wgt_mem  [WGT_DEPTH];
   logic signed [VALUE_W-1:0] bias_mem [BIAS_DEPTH];

   // derived geometry
   logic [PLANE_W-1:0]  plane_out, plane_in;
   logic [AREA_W-1:0]   area;
   logic [STRIDE_W-1:0] oc_stride;
   logic [KSIDE_W-1:0]  k_last;
   logic [CFG_W-1:0]    ocol;
   logic [ACT_AW-1:0]   off;

   // index decomposition
   logic [ADDR_W-1:0] addr_ff, addr_in, rem_ff, rem_in;
   logic [CFG_W-1:0]  oc_ff, oc_in, orow_ff, orow_in;
   logic [WGT_AW-1:0] wbase_ff, wbase_in;
   logic [ACT_AW-1:0] start_ff, start_in;

   // tap walk
   logic [CFG_W-1:0]   ic_ff, ic_in;
   logic [KSIDE_W-1:0] fr_ff, fr_in, fc_ff, fc_in;
   logic [ROW_W-1:0]   r_ff, r_in, c_ff, c_in;
   logic [ACT_AW-1:0]  ic_base_ff, ic_base_in, row_addr_ff, row_addr_in;
   logic [WGT_AW-1:0]  wi_ff, wi_in;
   logic [ACT_AW-1:0]  act_rd_addr;
   logic               in_bounds;

   // MAC pipe
   logic                      v1_ff, v2_ff, m1_ff, m2_ff, bias_ld_ff;
   logic signed [VALUE_W-1:0] act_q_ff, wgt_q_ff, bias_q_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      act_we, wgt_we, bias_we;

   // result
   logic [Q_W-1:0]     q;
   logic               sat_hi, sat_lo;
   logic [VALUE_W-1:0] res_value;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]         out_addr_ff;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic                      sat_ff;

   assign plane_out = PLANE_W'(cfg.out_side) * PLANE_W'(cfg.out_side);
   assign plane_in  = PLANE_W'(cfg.in_side) * PLANE_W'(cfg.in_side);
   assign area      = AREA_W'(cfg.kernel_side) * AREA_W'(cfg.kernel_side);
   assign oc_stride = STRIDE_W'(cfg.in_channel_count) * STRIDE_W'(area);
   assign k_last    = cfg.kernel_side - KSIDE_W'(1);
   assign ocol      = rem_ff[CFG_W-1:0];
   assign off       = start_ff + ACT_AW'(ocol);

   assign stat.rem_ge_plane = rem_ff >= ADDR_W'(plane_out);
   assign stat.oc_last      = oc_ff == (cfg.out_channel_count - CFG_W'(1));
   assign stat.rem_ge_side  = rem_ff >= ADDR_W'(cfg.out_side);
   assign stat.tap_last     = (ic_ff == (cfg.in_channel_count - CFG_W'(1)))
                              && (fr_ff == k_last) && (fc_ff == k_last);
   assign stat.pipe_busy    = v1_ff || v2_ff || bias_ld_ff;
   assign stat.out_busy     = rsp_valid_ff && !rsp_ready;

   // channel and row found by repeated subtraction
   always_comb begin
      addr_in  = addr_ff;
      rem_in   = rem_ff;
      oc_in    = oc_ff;
      orow_in  = orow_ff;
      wbase_in = wbase_ff;
      start_in = start_ff;
      if (cmd.capture) begin
         addr_in  = req_addr;
         rem_in   = req_addr;
         oc_in    = '0;
         orow_in  = '0;
         wbase_in = '0;
         start_in = '0;
      end
      if (cmd.oc_step) begin
         rem_in   = rem_ff - ADDR_W'(plane_out);
         oc_in    = oc_ff + CFG_W'(1);
         wbase_in = wbase_ff + WGT_AW'(oc_stride);
      end
      if (cmd.row_step) begin
         rem_in   = rem_ff - ADDR_W'(cfg.out_side);
         orow_in  = orow_ff + CFG_W'(1);
         start_in = start_ff + ACT_AW'(cfg.in_side);
      end
   end

   // walk ic, fr, fc; weights are contiguous so wi just counts
   always_comb begin
      ic_in       = ic_ff;
      fr_in       = fr_ff;
      fc_in       = fc_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      ic_base_in  = ic_base_ff;
      row_addr_in = row_addr_ff;
      wi_in       = wi_ff;
      if (cmd.tap_init) begin
         ic_in       = '0;
         fr_in       = '0;
         fc_in       = '0;
         r_in        = ROW_W'(orow_ff);
         c_in        = ROW_W'(ocol);
         ic_base_in  = '0;
         row_addr_in = off;
         wi_in       = wbase_ff;
      end
      if (cmd.tap_step) begin
         wi_in = wi_ff + WGT_AW'(1);
         if (fc_ff != k_last) begin
            fc_in = fc_ff + KSIDE_W'(1);
            c_in  = c_ff + ROW_W'(1);
         end else begin
            fc_in = '0;
            c_in  = ROW_W'(ocol);
            if (fr_ff != k_last) begin
               fr_in       = fr_ff + KSIDE_W'(1);
               r_in        = r_ff + ROW_W'(1);
               row_addr_in = row_addr_ff + ACT_AW'(cfg.in_side);
            end else begin
               fr_in       = '0;
               r_in        = ROW_W'(orow_ff);
               ic_in       = ic_ff + CFG_W'(1);
               ic_base_in  = ic_base_ff + ACT_AW'(plane_in);
               row_addr_in = ic_base_ff + ACT_AW'(plane_in) + off;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      rem_ff      <= rem_in;
      oc_ff       <= oc_in;
      orow_ff     <= orow_in;
      wbase_ff    <= wbase_in;
      start_ff    <= start_in;
      ic_ff       <= ic_in;
      fr_ff       <= fr_in;
      fc_ff       <= fc_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      ic_base_ff  <= ic_base_in;
      row_addr_ff <= row_addr_in;
      wi_ff       <= wi_in;
   end

   assign act_rd_addr = row_addr_ff + ACT_AW'(fc_ff);
   // taps past the right or bottom edge contribute zero
   assign in_bounds   = (r_ff < ROW_W'(cfg.in_side)) && (c_ff < ROW_W'(cfg.in_side));

   assign act_we  = cmd.load_write && (req_type == REQ_LOAD_ACT)
                    && (32'(req_addr) < ACT_DEPTH);
   assign wgt_we  = cmd.load_write && (req_type == REQ_LOAD_WGT)
                    && (32'(req_addr) < WGT_DEPTH);
   assign bias_we = cmd.load_write && (req_type == REQ_LOAD_BIAS)
                    && (32'(req_addr) < BIAS_DEPTH);

   always_ff @(posedge clock) begin
      if (act_we) act_mem[ACT_AW'(req_addr)] <= req_load_value;
      act_q_ff <= act_mem[act_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wgt_we) wgt_mem[WGT_AW'(req_addr)] <= req_load_value;
      wgt_q_ff <= wgt_mem[wi_ff];
   end

   always_ff @(posedge clock) begin
      if (bias_we) bias_mem[BIAS_AW'(req_addr)] <= req_load_value;
      bias_q_ff <= bias_mem[BIAS_AW'(oc_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         bias_ld_ff <= 1'b0;
      end else begin
         v1_ff      <= cmd.tap_step;
         v2_ff      <= v1_ff;
         bias_ld_ff <= cmd.tap_init;
      end
   end

   always_ff @(posedge clock) begin
      m1_ff   <= in_bounds;
      m2_ff   <= m1_ff;
      prod_ff <= act_q_ff * wgt_q_ff;
      if (bias_ld_ff) begin
         acc_ff <= {{(ACC_W-VALUE_W-FRAC_W){bias_q_ff[VALUE_W-1]}}, bias_q_ff,
                    {FRAC_W{1'b0}}};
      end else if (v2_ff && m2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // arithmetic shift floors; then clip to 16 bits
   assign q      = acc_ff[ACC_W-1:FRAC_W];
   assign sat_hi = !q[Q_W-1] && (|q[Q_W-2:VALUE_W-1]);
   assign sat_lo = q[Q_W-1] && !(&q[Q_W-2:VALUE_W-1]);
   assign res_value = sat_hi ? VALUE_POS_LIMIT :
                      sat_lo ? VALUE_NEG_LIMIT : q[VALUE_W-1:0];

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_addr_ff  <= addr_ff;
         out_value_ff <= res_value;
         sat_ff       <= sat_hi || sat_lo;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_addr  = out_addr_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_saturated = sat_ff;

`ifndef SYNTH
   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(v1_ff || v2_ff || bias_ld_ff))
      else $error("result taken before the MAC pipe drained");

   a_ic_range: assert property (@(posedge clock) disable iff (reset)
      cmd.tap_step |-> (ic_ff < cfg.in_channel_count))
      else $error("tap walk past the last input channel");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      cmd.tap_step |-> ((fr_ff < cfg.kernel_side) && (fc_ff < cfg.kernel_side)))
      else $error("tap walk outside the kernel");

   a_oc_range: assert property (@(posedge clock) disable iff (reset)
      cmd.oc_step |=> (oc_ff < cfg.out_channel_count))
      else $error("output channel search ran past the channel count");
`endif

endmodule

@@ rtl/direct_convolution_engine.sv @@
// Multichannel direct 2D convolution with one shared 16x16 MAC. Load words write
// activations, weights or biases. A compute word first splits its flat index into
// channel and row by repeated subtraction (an index past the last channel is
// dropped), then walks input channel, kernel row and kernel column one tap a cycle
// through the activation and weight memories, and drains a three-stage
// read/multiply/accumulate pipe; the next word is taken in the cycle the result is
// posted. Memories come up undefined and need no clearing pass. A finished result
// sits in an output register, so loads are taken while it waits; the next result
// is held back only while the previous one is still unread.
module direct_convolution_engine import dce_pkg::*; #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int MAX_SIDE         = 19,
   parameter int MAX_KERNEL       = 3
) (
   input  logic         clock,
   input  logic         reset,
   dce_req_if.sink      req_bus,
   dce_rsp_if.source    rsp_bus,
   dce_csr_if.sink      csr_bus
);

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;
   logic     req_is_compute;

   assign req_is_compute = req_bus.req_type == REQ_COMPUTE;
   assign req_bus.ready  = req_ready;

   dce_csr #(
      .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
      .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
      .MAX_SIDE         (MAX_SIDE),
      .MAX_KERNEL       (MAX_KERNEL)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   dce_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_is_compute (req_is_compute),
      .stat           (stat),
      .req_ready      (req_ready),
      .cmd            (cmd)
   );

   dce_datapath #(
      .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
      .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
      .MAX_SIDE         (MAX_SIDE),
      .MAX_KERNEL       (MAX_KERNEL)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .req_type       (req_bus.req_type),
      .req_addr       (req_bus.addr),
      .req_load_value (req_bus.load_value),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_out_addr   (rsp_bus.out_addr),
      .rsp_out_value  (rsp_bus.out_value),
      .rsp_saturated  (rsp_bus.saturated),
      .stat           (stat)
   );

endmodule

@@ tb/dce_conv_checker.sv @@
module dce_conv_checker import dce_pkg::*; #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int MAX_SIDE         = 19,
   parameter int MAX_KERNEL       = 3
) (
   input  logic    clock,
   input  logic    reset,
   dce_req_if      req_bus,
   dce_rsp_if      rsp_bus,
   dce_csr_if      csr_bus,
   output cfg_type active_cfg,
   output int      pending,
   output int      errors,
   output int      results_seen,
   output int      clipped_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ACT_DEPTH  = MAX_IN_CHANNELS * MAX_SIDE * MAX_SIDE;
   localparam int WGT_DEPTH  = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int BIAS_DEPTH = MAX_OUT_CHANNELS;

   typedef struct {
      logic [ADDR_W-1:0]         point;
      logic signed [VALUE_W-1:0] value;
      logic                      clipped;
   } conv_point_type;

   logic signed [VALUE_W-1:0] act_copy  [ACT_DEPTH];
   logic signed [VALUE_W-1:0] wgt_copy  [WGT_DEPTH];
   logic signed [VALUE_W-1:0] bias_copy [BIAS_DEPTH];

   int oc_n, ic_n, os_n, is_n, k_n;
   conv_point_type points_due[$];

   function automatic int clamp_setting(input int raw, input int hi);
      if (raw < 1) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   // bias + sum of act * weight over channels and taps, Q40.8 in 48 bits
   function automatic conv_point_type conv_point(input logic [ADDR_W-1:0] idx);
      conv_point_type res;
      int plane, area, oc, rem, orow, ocol, r, c, ai, wi;
      logic signed [ACC_W-1:0] acc;
      logic signed [PROD_W-1:0] prod;
      plane = os_n * os_n;
      area  = k_n * k_n;
      oc    = int'(idx) / plane;
      rem   = int'(idx) % plane;
      orow  = rem / os_n;
      ocol  = rem % os_n;
      acc   = bias_copy[oc];
      acc   = acc <<< FRAC_W;
      for (int ic = 0; ic < ic_n; ic++) begin
         for (int fr = 0; fr < k_n; fr++) begin
            for (int fc = 0; fc < k_n; fc++) begin
               r = orow + fr;
               c = ocol + fc;
               // taps past the right or bottom edge read as zero
               if (r < is_n && c < is_n) begin
                  ai   = ic * is_n * is_n + r * is_n + c;
                  wi   = oc * ic_n * area + ic * area + fr * k_n + fc;
                  prod = act_copy[ai] * wgt_copy[wi];
                  acc  = acc + prod;
               end
            end
         end
      end
      acc = acc >>> FRAC_W;
      res.point   = idx;
      res.clipped = 1'b1;
      if (acc > 48'sd32767) begin
         res.value = VALUE_POS_LIMIT;
      end else if (acc < -48'sd32768) begin
         res.value = VALUE_NEG_LIMIT;
      end else begin
         res.value   = acc[VALUE_W-1:0];
         res.clipped = 1'b0;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string note);
      $display("[%0t] mismatch: %s", $time, note);
      errors++;
   endtask

   always @(posedge clock) begin
      conv_point_type want;
      if (reset) begin
         foreach (act_copy[i]) act_copy[i] = '0;
         foreach (wgt_copy[i]) wgt_copy[i] = '0;
         foreach (bias_copy[i]) bias_copy[i] = '0;
         oc_n = RST_CHANNELS;
         ic_n = RST_CHANNELS;
         os_n = RST_SIDE;
         is_n = RST_SIDE;
         k_n  = RST_KERNEL;
         points_due.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (rsp_bus.saturated === 1'b1) clipped_seen++;
            if (points_due.size() == 0) begin
               report_mismatch($sformatf("result for point %0d with nothing outstanding",
                                         rsp_bus.out_addr));
            end else begin
               want = points_due.pop_front();
               if (rsp_bus.out_addr !== want.point)
                  report_mismatch($sformatf("out_addr got %0d expected %0d",
                                            rsp_bus.out_addr, want.point));
               if (rsp_bus.out_value !== want.value)
                  report_mismatch($sformatf("out_value at point %0d got %0d expected %0d",
                                            want.point, rsp_bus.out_value, want.value));
               if (rsp_bus.saturated !== want.clipped)
                  report_mismatch($sformatf("saturated at point %0d got %0b expected %0b",
                                            want.point, rsp_bus.saturated, want.clipped));
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_OUT_CHANNELS: oc_n = clamp_setting(csr_bus.data, MAX_OUT_CHANNELS);
               REG_IN_CHANNELS:  ic_n = clamp_setting(csr_bus.data, MAX_IN_CHANNELS);
               REG_OUT_SIDE:     os_n = clamp_setting(csr_bus.data, MAX_SIDE);
               REG_IN_SIDE:      is_n = clamp_setting(csr_bus.data, MAX_SIDE);
               REG_KERNEL_SIDE:  k_n  = clamp_setting(csr_bus.data[KSIDE_W-1:0], MAX_KERNEL);
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            case (req_bus.req_type)
               REQ_LOAD_ACT:
                  if (req_bus.addr < ACT_DEPTH) act_copy[req_bus.addr] = req_bus.load_value;
               REQ_LOAD_WGT:
                  if (req_bus.addr < WGT_DEPTH) wgt_copy[req_bus.addr] = req_bus.load_value;
               REQ_LOAD_BIAS:
                  if (req_bus.addr < BIAS_DEPTH) bias_copy[req_bus.addr] = req_bus.load_value;
               REQ_COMPUTE:
                  if (int'(req_bus.addr) < oc_n * os_n * os_n)
                     points_due.push_back(conv_point(req_bus.addr));
               default: ;
            endcase
         end
      end
      pending = points_due.size();
      active_cfg.out_channel_count = CFG_W'(oc_n);
      active_cfg.in_channel_count  = CFG_W'(ic_n);
      active_cfg.out_side          = CFG_W'(os_n);
      active_cfg.in_side           = CFG_W'(is_n);
      active_cfg.kernel_side       = KSIDE_W'(k_n);
   end

endmodule

@@ tb/tb_direct_convolution_engine.sv @@
module tb_direct_convolution_engine;
   import dce_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_IN_CHANNELS  = 16;
   localparam int MAX_OUT_CHANNELS = 16;
   localparam int MAX_SIDE         = 19;
   localparam int MAX_KERNEL       = 3;
   localparam int ACT_DEPTH  = MAX_IN_CHANNELS * MAX_SIDE * MAX_SIDE;
   localparam int WGT_DEPTH  = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int BIAS_DEPTH = MAX_OUT_CHANNELS;
   localparam int ADDR_MAX   = (1 << ADDR_W) - 1;

   localparam int PHASES        = 8;
   localparam int SETTLE_CYCLES = 250;
   localparam int HOLD_CYCLES   = 1500;
   localparam int CYCLE_LIMIT   = 1000000;

   logic clock;
   logic reset;

   dce_req_if req_bus ();
   dce_rsp_if rsp_bus ();
   dce_csr_if csr_bus ();

   cfg_type active_cfg;
   int      pending, errors, results_seen, clipped_seen;
   int      words_sent;
   int      cycle_count;
   int      value_mode;   // 0: full range, 1: small values with rare extremes
   bit      calm;
   bit      hold_off;

   bit act_done  [ACT_DEPTH];
   bit wgt_done  [WGT_DEPTH];
   bit bias_done [BIAS_DEPTH];

   // raw settings: out ch, in ch, out side, in side, kernel; zero and 31 test clamping
   logic [CFG_W-1:0] phase_cfg [PHASES][5] = '{
      '{5'd4,  5'd3,  5'd4,  5'd5,  5'd2},
      '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
      '{5'd31, 5'd2,  5'd2,  5'd3,  5'd3},
      '{5'd3,  5'd31, 5'd2,  5'd4,  5'd1},
      '{5'd2,  5'd2,  5'd31, 5'd20, 5'd3},
      '{5'd5,  5'd4,  5'd6,  5'd3,  5'd3},
      '{5'd16, 5'd16, 5'd19, 5'd19, 5'd3},
      '{5'd2,  5'd3,  5'd5,  5'd5,  5'd1}
   };
   int phase_budget [PHASES] = '{100, 60, 110, 110, 110, 100, 300, 60};
   int phase_mode   [PHASES] = '{1, 0, 1, 1, 0, 1, 1, 0};

   direct_convolution_engine uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   dce_conv_checker #(
      .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
      .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
      .MAX_SIDE         (MAX_SIDE),
      .MAX_KERNEL       (MAX_KERNEL)
   ) conv_check (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_bus      (csr_bus),
      .active_cfg   (active_cfg),
      .pending      (pending),
      .errors       (errors),
      .results_seen (results_seen),
      .clipped_seen (clipped_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("direct_convolution_engine test failed");
      $finish;
   end

   // result side: random stalls, a calm stretch, and one long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_off = 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 17);
         end
      end
   end

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int v;
      if (value_mode == 0) return VALUE_W'($urandom);
      if ($urandom_range(19) == 0) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      v = int'($urandom_range(512)) - 256;
      return VALUE_W'(v);
   endfunction

   // positions cluster near the corners of the output plane so footprints get reused
   function automatic int near_edge(input int side);
      int span;
      span = (side > 4) ? 3 : side - 1;
      if ($urandom_range(1)) return $urandom_range(span);
      return side - 1 - $urandom_range(span);
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic push_req(input req_kind_type kind, input int addr,
                           input logic signed [VALUE_W-1:0] value);
      while (!calm && $urandom_range(99) < 17) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.addr       <= ADDR_W'(addr);
      req_bus.load_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      words_sent++;
      case (kind)
         REQ_LOAD_ACT:  if (addr < ACT_DEPTH) act_done[addr] = 1'b1;
         REQ_LOAD_WGT:  if (addr < WGT_DEPTH) wgt_done[addr] = 1'b1;
         REQ_LOAD_BIAS: if (addr < BIAS_DEPTH) bias_done[addr] = 1'b1;
         default: ;
      endcase
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CFG_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [CFG_W-1:0] occ, input logic [CFG_W-1:0] icc,
                                 input logic [CFG_W-1:0] osd, input logic [CFG_W-1:0] isd,
                                 input logic [CFG_W-1:0] ksd);
      write_reg(REG_OUT_CHANNELS, occ);
      write_reg(REG_IN_CHANNELS, icc);
      write_reg(REG_OUT_SIDE, osd);
      write_reg(REG_IN_SIDE, isd);
      write_reg(REG_KERNEL_SIDE, ksd);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // load every entry a compute at (oc, row, col) could touch that is still unwritten
   task automatic cover_footprint(input int oc, input int row, input int col);
      int icc, isd, ksd, area, wi, ai;
      icc  = active_cfg.in_channel_count;
      isd  = active_cfg.in_side;
      ksd  = active_cfg.kernel_side;
      area = ksd * ksd;
      if (!bias_done[oc]) push_req(REQ_LOAD_BIAS, oc, pick_value());
      for (int ic = 0; ic < icc; ic++) begin
         for (int fr = 0; fr < ksd; fr++) begin
            for (int fc = 0; fc < ksd; fc++) begin
               wi = oc * icc * area + ic * area + fr * ksd + fc;
               ai = ic * isd * isd + (row + fr) * isd + col + fc;
               if (wi < WGT_DEPTH && !wgt_done[wi]) push_req(REQ_LOAD_WGT, wi, pick_value());
               if (ai < ACT_DEPTH && !act_done[ai]) push_req(REQ_LOAD_ACT, ai, pick_value());
            end
         end
      end
   endtask

   task automatic run_phase(input int budget);
      int stop_at, pick, oc, row, col, occ, icc, osd, ksd, limit, addr;
      req_kind_type kind;
      stop_at = words_sent + budget;
      occ     = active_cfg.out_channel_count;
      icc     = active_cfg.in_channel_count;
      osd     = active_cfg.out_side;
      ksd     = active_cfg.kernel_side;
      limit   = occ * osd * osd;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            // wide filters: stay on the first two output channels to bound the loads
            oc  = (icc * ksd * ksd > 64) ? $urandom_range(occ > 1 ? 1 : 0)
                                        : $urandom_range(occ - 1);
            row = near_edge(osd);
            col = near_edge(osd);
            cover_footprint(oc, row, col);
            push_req(REQ_COMPUTE, oc * osd * osd + row * osd + col, VALUE_W'($urandom));
         end else if (pick < 66) begin
            push_req(REQ_COMPUTE, $urandom_range(ADDR_MAX, limit), VALUE_W'($urandom));
         end else begin
            kind = req_kind_type'($urandom_range(2));
            if (pick < 80) begin
               case (kind)
                  REQ_LOAD_ACT:  addr = $urandom_range(ACT_DEPTH - 1);
                  REQ_LOAD_WGT:  addr = $urandom_range(WGT_DEPTH - 1);
                  default:       addr = $urandom_range(BIAS_DEPTH - 1);
               endcase
            end else begin
               addr = $urandom_range(ADDR_MAX);
            end
            push_req(kind, addr, pick_value());
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_LOAD_ACT;
      req_bus.addr       = '0;
      req_bus.load_value = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = REG_OUT_CHANNELS;
      csr_bus.data       = '0;
      calm               = 1'b0;
      hold_off           = 1'b0;
      value_mode         = 0;
      words_sent         = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // two output channels of a single 1x1 point: each word is easy to follow
      apply_settings(5'd2, 5'd1, 5'd1, 5'd1, 5'd1);
      push_req(REQ_LOAD_BIAS, 0, 16'sh7FFF);
      push_req(REQ_LOAD_BIAS, 1, 16'sh8000);
      push_req(REQ_LOAD_ACT, 0, 16'sh7FFF);
      push_req(REQ_LOAD_WGT, 0, 16'sh7FFF);
      push_req(REQ_LOAD_WGT, 1, 16'sh8000);
      push_req(REQ_COMPUTE, 0, 16'sh0000);
      push_req(REQ_COMPUTE, 1, 16'shFFFF);
      // zero activation leaves the bias alone, exactly at both limits
      push_req(REQ_LOAD_ACT, 0, 16'sh0000);
      push_req(REQ_COMPUTE, 0, 16'sh0000);
      push_req(REQ_COMPUTE, 1, 16'sh0000);
      // a -1 bias plus a tiny negative product rounds toward minus infinity
      push_req(REQ_LOAD_BIAS, 0, -16'sd1);
      push_req(REQ_LOAD_ACT, 0, 16'sd1);
      push_req(REQ_LOAD_WGT, 0, -16'sd1);
      push_req(REQ_COMPUTE, 0, 16'sh0000);
      // out-of-range loads and points past the output plane are dropped
      push_req(REQ_LOAD_ACT, ADDR_MAX, 16'shFFFF);
      push_req(REQ_LOAD_WGT, WGT_DEPTH, 16'sh1234);
      push_req(REQ_LOAD_BIAS, BIAS_DEPTH, 16'sh5555);
      push_req(REQ_COMPUTE, 2, 16'sh0000);
      push_req(REQ_COMPUTE, ADDR_MAX, 16'sh7FFF);
      push_req(REQ_COMPUTE, 0, 16'sh0000);
      push_req(REQ_COMPUTE, 1, 16'sh0000);
      settle_block();

      for (int p = 0; p < PHASES; p++) begin
         apply_settings(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                        phase_cfg[p][3], phase_cfg[p][4]);
         value_mode = phase_mode[p];
         calm       = (p == 4);
         if (p == 2) hold_off = 1'b1;
         run_phase(phase_budget[p]);
         settle_block();
      end
      calm = 1'b0;

      $display("run covered %0d request words under %0d register settings, one %0d-cycle stall",
               words_sent, PHASES + 1, HOLD_CYCLES);
      $display("%0d convolution points compared, %0d of them clipped, in %0d cycles",
               results_seen, clipped_seen, cycle_count);
      if (errors == 0) begin
         $display("direct_convolution_engine test passed");
      end else begin
         $display("direct_convolution_engine test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/dce_pkg.sv
rtl/dce_req_if.sv
rtl/dce_rsp_if.sv
rtl/dce_csr_if.sv
rtl/dce_csr.sv
rtl/dce_ctrl.sv
rtl/dce_datapath.sv
rtl/direct_convolution_engine.sv
tb/dce_conv_checker.sv
tb/tb_direct_convolution_engine.sv
